>>> rtl/kdh_pkg.sv
// kdh_pkg: shared types, constants and keycode ROM for the keypad debounce
// and HID report block. No dependencies.
package kdh_pkg;

  localparam int NUM_SLOTS = 6;
  localparam int RAW_BITS  = 6;

  localparam logic [3:0] THRESHOLD_RESET = 4'd10;
  localparam logic [9:0] IDLE_RESET      = 10'd500;

  typedef enum logic [1:0] {
    CMD_SCAN = 2'd0,
    CMD_TICK = 2'd1,
    CMD_POLL = 2'd2,
    CMD_NONE = 2'd3
  } cmd_t;

  typedef enum logic [0:0] {
    REG_THRESHOLD = 1'b0,
    REG_IDLE      = 1'b1
  } reg_index_t;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_STEP   = 3'b010,
    ST_FINISH = 3'b100
  } state_t;

  typedef logic [NUM_SLOTS-1:0][7:0] report_t;

  // sequencer controls to the key ring and report builder
  typedef struct packed {
    logic start;
    logic step;
    logic scan;
  } seq_ctl_t;

  // key currently at the head of the ring
  typedef struct packed {
    logic       down;
    logic       first;
    logic       last;
    logic [2:0] row;
    logic [2:0] col;
  } key_pos_t;

  localparam logic [7:0] KEY_ROM [2][2][3] = '{
    '{ '{8'h00, 8'h21, 8'h22}, '{8'h1E, 8'h1F, 8'h20} },
    '{ '{8'h00, 8'h26, 8'h27}, '{8'h23, 8'h24, 8'h25} }
  };

  function automatic logic [7:0] rom_code(input logic layer, input logic [2:0] row,
                                          input logic [2:0] col);
    logic [7:0] code;
    code = 8'h00;
    if (row < 3'd2 && col < 3'd3)
      code = KEY_ROM[layer][row[0]][col[1:0]];
    return code;
  endfunction

endpackage

>>> rtl/kdh_key_ring.sv
// kdh_key_ring: debounce counters held in a rotating ring with one shared
// saturating up/down unit at its head. Depends on kdh_pkg.
module kdh_key_ring #(
  parameter int KEY_ROWS = 2,
  parameter int KEY_COLS = 3
) (
  input  logic                             clk,
  input  logic                             rst,
  input  kdh_pkg::seq_ctl_t                ctl,
  input  logic [3:0]                       threshold,
  input  logic [kdh_pkg::RAW_BITS-1:0]     raw_keys,
  output kdh_pkg::key_pos_t                pos
);
  import kdh_pkg::*;

  localparam int NumKeys = KEY_ROWS * KEY_COLS;
  localparam int RowW    = (KEY_ROWS > 1) ? $clog2(KEY_ROWS) : 1;
  localparam int ColW    = (KEY_COLS > 1) ? $clog2(KEY_COLS) : 1;

  logic [3:0]          ring [NumKeys];
  logic [RAW_BITS-1:0] raw_sh;
  logic [RowW-1:0]     row;
  logic [ColW-1:0]     col;
  logic [3:0]          head;
  logic [3:0]          head_next;
  logic                col_last;

  assign head     = ring[0];
  assign col_last = (col == ColW'(KEY_COLS - 1));

  always_comb begin
    head_next = head;
    if (ctl.scan) begin
      if (raw_sh[0]) begin
        if (head < threshold)
          head_next = head + 4'd1;
      end else if (head != 4'd0) begin
        head_next = head - 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NumKeys; i++)
        ring[i] <= 4'd0;
      row    <= '0;
      col    <= '0;
      raw_sh <= '0;
    end else if (ctl.start) begin
      row    <= '0;
      col    <= '0;
      raw_sh <= raw_keys;
    end else if (ctl.step) begin
      for (int i = 0; i < NumKeys - 1; i++)
        ring[i] <= ring[i+1];
      ring[NumKeys-1] <= head_next;
      raw_sh <= {1'b0, raw_sh[RAW_BITS-1:1]};
      if (col_last) begin
        col <= '0;
        row <= row + RowW'(1);
      end else begin
        col <= col + ColW'(1);
      end
    end
  end

  assign pos.down  = (head == threshold);
  assign pos.first = (row == '0) && (col == '0);
  assign pos.last  = (row == RowW'(KEY_ROWS - 1)) && col_last;
  assign pos.row   = 3'(row);
  assign pos.col   = 3'(col);

endmodule

>>> rtl/kdh_report.sv
// kdh_report: compacts pressed keys into report slots one key per cycle and
// holds the last sent report. Depends on kdh_pkg.
module kdh_report #(
  parameter int MAX_REPORT_KEYS = 6
) (
  input  logic              clk,
  input  logic              rst,
  input  kdh_pkg::seq_ctl_t ctl,
  input  kdh_pkg::key_pos_t pos,
  input  logic              store,
  output kdh_pkg::report_t  report,
  output logic              differs
);
  import kdh_pkg::*;

  localparam logic [2:0] MaxSlots = 3'(MAX_REPORT_KEYS);

  report_t    last;
  logic [2:0] used;
  logic       layer;

  always_ff @(posedge clk) begin
    if (rst) begin
      last  <= '0;
      used  <= 3'd0;
      layer <= 1'b0;
    end else begin
      if (ctl.start) begin
        used   <= 3'd0;
        report <= '0;
      end else if (ctl.step && !ctl.scan) begin
        if (pos.first) begin
          layer <= pos.down;
        end else if (pos.down && used < MaxSlots) begin
          report[used] <= rom_code(layer, pos.row, pos.col);
          used         <= used + 3'd1;
        end
      end
      if (store)
        last <= report;
    end
  end

  assign differs = (report != last);

endmodule

>>> rtl/keypad_debounce_hid_report.sv
// keypad_debounce_hid_report: top level, sequencer, registers and result stage.
// Scan and poll items pass every counter through the shared debounce unit, one
// counter per cycle; a tick only steps the idle countdown down.
// A poll waits in its finish state while an earlier result is still unread.
// Synchronous reset: counters, last report and idle countdown clear, registers
// load threshold 10 and idle period 500. Depends on kdh_pkg, kdh_key_ring, kdh_report.
module keypad_debounce_hid_report #(
  parameter int KEY_ROWS        = 2,
  parameter int KEY_COLS        = 3,
  parameter int MAX_REPORT_KEYS = 6
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic [0:0]                   cfg_index,
  input  logic [9:0]                   cfg_data,
  input  logic                         item_valid,
  output logic                         item_stall,
  input  logic [1:0]                   cmd,
  input  logic [kdh_pkg::RAW_BITS-1:0] raw_keys,
  input  logic                         endpoint_ready,
  output logic                         result_valid,
  input  logic                         result_stall,
  output logic                         sent,
  output logic [7:0]                   key_code_0,
  output logic [7:0]                   key_code_1,
  output logic [7:0]                   key_code_2,
  output logic [7:0]                   key_code_3,
  output logic [7:0]                   key_code_4,
  output logic [7:0]                   key_code_5
);
  import kdh_pkg::*;

  state_t    state;
  logic [3:0] threshold;
  logic [9:0] idle_period;
  logic [9:0] idle_remaining;
  logic       scan_op;
  logic       ready_q;
  report_t    result;
  report_t    report;
  seq_ctl_t   ctl;
  key_pos_t   pos;
  logic       accept;
  logic       out_free;
  logic       finish;
  logic       expired;
  logic       send;
  logic       differs;
  cmd_t       cmd_in;

  assign cmd_in     = cmd_t'(cmd);
  assign item_stall = (state != ST_IDLE);
  assign accept     = item_valid && !item_stall;
  assign out_free   = !result_valid || !result_stall;
  assign finish     = (state == ST_FINISH) && (scan_op || out_free);
  assign expired    = (idle_period != 10'd0) && (idle_remaining == 10'd0);
  assign send       = ready_q && (expired || differs);

  assign ctl.start = accept && (cmd_in == CMD_SCAN || cmd_in == CMD_POLL);
  assign ctl.step  = (state == ST_STEP);
  assign ctl.scan  = scan_op;

  kdh_key_ring #(
    .KEY_ROWS (KEY_ROWS),
    .KEY_COLS (KEY_COLS)
  ) u_ring (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .threshold (threshold),
    .raw_keys  (raw_keys),
    .pos       (pos)
  );

  kdh_report #(
    .MAX_REPORT_KEYS (MAX_REPORT_KEYS)
  ) u_report (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .pos     (pos),
    .store   (finish && !scan_op && send),
    .report  (report),
    .differs (differs)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      threshold      <= THRESHOLD_RESET;
      idle_period    <= IDLE_RESET;
      idle_remaining <= 10'd0;
      scan_op        <= 1'b0;
      ready_q        <= 1'b0;
      result_valid   <= 1'b0;
      sent           <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (reg_index_t'(cfg_index))
          REG_THRESHOLD: threshold   <= cfg_data[3:0];
          REG_IDLE:      idle_period <= cfg_data;
        endcase
      end

      if (finish && !scan_op)
        result_valid <= 1'b1;
      else if (result_valid && !result_stall)
        result_valid <= 1'b0;

      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            scan_op <= (cmd_in == CMD_SCAN);
            ready_q <= endpoint_ready;
            if (cmd_in == CMD_SCAN || cmd_in == CMD_POLL)
              state <= ST_STEP;
            else if (cmd_in == CMD_TICK && idle_remaining != 10'd0)
              idle_remaining <= idle_remaining - 10'd1;
          end
        end
        ST_STEP: begin
          if (pos.last)
            state <= ST_FINISH;
        end
        ST_FINISH: begin
          if (finish) begin
            state <= ST_IDLE;
            if (!scan_op) begin
              if (expired)
                idle_remaining <= idle_period;
              sent   <= send;
              result <= report;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign key_code_0 = result[0];
  assign key_code_1 = result[1];
  assign key_code_2 = result[2];
  assign key_code_3 = result[3];
  assign key_code_4 = result[4];
  assign key_code_5 = result[5];

endmodule
